@@ design/tlh_pkg.sv @@
// ---------------------------------------------------------------------------
// tlh_pkg: shared types and constants for the thermal level hysteresis core
// Field widths, register indexes, reset values and the level update function.
// ---------------------------------------------------------------------------
package tlh_pkg;

  localparam int TEMP_W     = 19;
  localparam int LEVEL_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_ENTRY  = 3;

  localparam logic [LEVEL_W-1:0] MAX_LEVELS = 2'd3;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [LEVEL_W-1:0]       level_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_DESCENDING = 3'd0;
  localparam cfg_idx_t REG_LEVELS     = 3'd1;
  localparam cfg_idx_t REG_RISE_ONE   = 3'd2;
  localparam cfg_idx_t REG_RISE_TWO   = 3'd3;
  localparam cfg_idx_t REG_RISE_THREE = 3'd4;
  localparam cfg_idx_t REG_CLR_ONE    = 3'd5;
  localparam cfg_idx_t REG_CLR_TWO    = 3'd6;
  localparam cfg_idx_t REG_CLR_THREE  = 3'd7;

  // Reset values
  localparam level_t RST_LEVELS     = 2'd3;
  localparam temp_t  RST_RISE_ONE   = 19'sd60000;
  localparam temp_t  RST_RISE_TWO   = 19'sd70000;
  localparam temp_t  RST_RISE_THREE = 19'sd80000;
  localparam temp_t  RST_CLR_ONE    = 19'sd55000;
  localparam temp_t  RST_CLR_TWO    = 19'sd65000;
  localparam temp_t  RST_CLR_THREE  = 19'sd75000;

  typedef struct packed {
    logic   descending;
    level_t levels;
    temp_t  rise_one;
    temp_t  rise_two;
    temp_t  rise_three;
    temp_t  clr_one;
    temp_t  clr_two;
    temp_t  clr_three;
  } cfg_t;

  // Walk the level up through reached rise thresholds, or down through passed
  // clear thresholds. rise_hit[k] covers entry k; clr_hit[k] leaves level k
  // (index zero is never set since level zero cannot drop).
  function automatic level_t next_level(level_t cur, level_t n_raw,
                                        logic [NUM_ENTRY:0] rise_hit,
                                        logic [NUM_ENTRY:0] clr_hit);
    level_t n;
    level_t lev;
    n = (n_raw == 2'd0) ? 2'd1 : n_raw;
    if (n > MAX_LEVELS) n = MAX_LEVELS;
    lev = (cur > n) ? n : cur;
    if ((lev < n) && rise_hit[lev]) begin
      for (int i = 0; i < NUM_ENTRY; i++) begin
        if ((lev < n) && rise_hit[lev]) lev = lev + 2'd1;
      end
    end else if ((lev != 2'd0) && clr_hit[lev]) begin
      for (int i = 0; i < NUM_ENTRY; i++) begin
        if ((lev != 2'd0) && clr_hit[lev]) lev = lev - 2'd1;
      end
    end
    return lev;
  endfunction

endpackage

@@ design/tlh_level_calc.sv @@
// ---------------------------------------------------------------------------
// tlh_level_calc: threshold comparators and level update
// Compares one sample against all thresholds and returns the new level.
// ---------------------------------------------------------------------------
module tlh_level_calc (
  input  tlh_pkg::cfg_t   cfg,
  input  tlh_pkg::temp_t  temperature,
  input  tlh_pkg::level_t cur_level,
  output tlh_pkg::level_t new_level
);

  logic [tlh_pkg::NUM_ENTRY:0] rise_hit;
  logic [tlh_pkg::NUM_ENTRY:0] clr_hit;
  logic [tlh_pkg::NUM_ENTRY-1:0] ge_rise;
  logic [tlh_pkg::NUM_ENTRY-1:0] le_rise;
  logic [tlh_pkg::NUM_ENTRY-1:0] lt_clr;
  logic [tlh_pkg::NUM_ENTRY-1:0] gt_clr;

  always_comb begin
    ge_rise = {temperature >= cfg.rise_three, temperature >= cfg.rise_two,
               temperature >= cfg.rise_one};
    le_rise = {temperature <= cfg.rise_three, temperature <= cfg.rise_two,
               temperature <= cfg.rise_one};
    lt_clr  = {temperature < cfg.clr_three, temperature < cfg.clr_two,
               temperature < cfg.clr_one};
    gt_clr  = {temperature > cfg.clr_three, temperature > cfg.clr_two,
               temperature > cfg.clr_one};
    // mirror every comparison in descending mode
    rise_hit = {1'b0, cfg.descending ? le_rise : ge_rise};
    clr_hit  = {cfg.descending ? gt_clr : lt_clr, 1'b0};
    new_level = tlh_pkg::next_level(cur_level, cfg.levels, rise_hit, clr_hit);
  end

endmodule

@@ design/thermal_level_hysteresis_core.sv @@
// ---------------------------------------------------------------------------
// thermal_level_hysteresis_core: multi-level thermal threshold with hysteresis
// Tracks the thermal level per temperature sample and emits the new level.
// ---------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   in_      | in_valid / in_stall  | in_temperature (19b signed)
//   out_     | out_valid / out_stall| out_thermal_level (2b)
//   cfg_     | cfg_valid / cfg_ready| cfg_index (3b), cfg_data (19b)
//
// One word per cycle sustained while out_stall is low; a sample taken into the
// input register is compared and loaded into the result register once that
// register frees up, and its level shows on out_ (input register, then compare
// and result register). The level register updates in the same cycle as the
// result register, so back-to-back samples see each other's level with no
// bubble. rst_n (synchronous) clears valids and the level and loads the default
// thresholds. out_stall holds the result and, once the input register is
// full too, raises in_stall. cfg_ready is always high.
//
module thermal_level_hysteresis_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tlh_pkg::temp_t         in_temperature,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tlh_pkg::level_t        out_thermal_level,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  tlh_pkg::cfg_idx_t      cfg_index,
  input  logic [tlh_pkg::TEMP_W-1:0] cfg_data
);

  tlh_pkg::cfg_t   cfg_r;
  logic            s1_valid_r;
  tlh_pkg::temp_t  s1_temp_r;
  logic            out_valid_r;
  tlh_pkg::level_t out_level_r;
  tlh_pkg::level_t level_r;
  tlh_pkg::level_t level_nxt;
  logic            s2_advance;
  logic            s1_take;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.descending <= 1'b0;
      cfg_r.levels     <= tlh_pkg::RST_LEVELS;
      cfg_r.rise_one   <= tlh_pkg::RST_RISE_ONE;
      cfg_r.rise_two   <= tlh_pkg::RST_RISE_TWO;
      cfg_r.rise_three <= tlh_pkg::RST_RISE_THREE;
      cfg_r.clr_one    <= tlh_pkg::RST_CLR_ONE;
      cfg_r.clr_two    <= tlh_pkg::RST_CLR_TWO;
      cfg_r.clr_three  <= tlh_pkg::RST_CLR_THREE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlh_pkg::REG_DESCENDING: cfg_r.descending <= cfg_data[0];
        tlh_pkg::REG_LEVELS:     cfg_r.levels     <= cfg_data[1:0];
        tlh_pkg::REG_RISE_ONE:   cfg_r.rise_one   <= cfg_data;
        tlh_pkg::REG_RISE_TWO:   cfg_r.rise_two   <= cfg_data;
        tlh_pkg::REG_RISE_THREE: cfg_r.rise_three <= cfg_data;
        tlh_pkg::REG_CLR_ONE:    cfg_r.clr_one    <= cfg_data;
        tlh_pkg::REG_CLR_TWO:    cfg_r.clr_two    <= cfg_data;
        tlh_pkg::REG_CLR_THREE:  cfg_r.clr_three  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register frees up when empty or when its word is taken
  assign s2_advance = !out_valid_r || !out_stall;
  // Input register takes a word when empty or when it moves on
  assign in_stall   = s1_valid_r && !s2_advance;
  assign s1_take    = in_valid && !in_stall;

  tlh_level_calc u_calc (
    .cfg         (cfg_r),
    .temperature (s1_temp_r),
    .cur_level   (level_r),
    .new_level   (level_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s2_advance || !s1_valid_r) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_temp_r <= in_temperature;
    end
  end

  // Result register and level state advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      level_r     <= '0;
    end else if (s2_advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        level_r <= level_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_advance && s1_valid_r) begin
      out_level_r <= level_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_thermal_level = out_level_r;

endmodule

@@ design/tlh_checker.sv @@
// ---------------------------------------------------------------------------
// tlh_checker: port-level checks for the thermal level hysteresis core
// Watches handshakes and reset behavior on the top-level ports.
// ---------------------------------------------------------------------------
module tlh_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input tlh_pkg::level_t out_thermal_level
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_thermal_level))
    else $error("stalled result word changed");

  // Backpressure only passes through when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Drop all words on reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind thermal_level_hysteresis_core tlh_checker u_tlh_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_thermal_level (out_thermal_level)
);

@@ test/thermal_level_hysteresis_core_test.sv @@
// ---------------------------------------------------------------------------
// thermal_level_hysteresis_core_test: self-checking bench for the level core
// Streams temperature words through the core under random sender bursts and
// receiver stalls, predicts every level word in step with accepted samples,
// and compares each delivered level word in order. Thresholds, mode and the
// number of levels change between phases while the core is idle.
// ---------------------------------------------------------------------------
module thermal_level_hysteresis_core_test;
  import tlh_pkg::*;

  localparam temp_t TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};
  localparam temp_t TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
  localparam int RANDOM_PHASES = 14;
  localparam int WORDS_PER_PHASE = 102;

  typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_mode_e;
  typedef enum logic [1:0] {SETUP_ORDERED, SETUP_SCATTERED, SETUP_EXTREME} setup_style_e;

  logic clk;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  temp_t             in_temperature = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  level_t            out_thermal_level;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_idx_t          cfg_index = '0;
  logic [TEMP_W-1:0] cfg_data = '0;

  thermal_level_hysteresis_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_temperature    (in_temperature),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_thermal_level (out_thermal_level),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow copy of the core's registers and level, kept by the bench.
  logic   mirror_descending;
  level_t mirror_levels;
  temp_t  mirror_rise [NUM_ENTRY];
  temp_t  mirror_clear [NUM_ENTRY];
  level_t tracked_level;

  temp_t  temp_backlog [$];   // samples waiting for the driver
  level_t level_due [$];      // predicted level words, oldest first
  int     mismatch_count = 0;
  int     level_words_seen = 0;

  // ------------------------------------------------------------------------
  // Level predictor
  // ------------------------------------------------------------------------

  // Sample reaches a rise threshold (mirrored in descending mode).
  function automatic logic climbs(temp_t t, temp_t thr);
    return mirror_descending ? (t <= thr) : (t >= thr);
  endfunction

  // Sample passes a clear threshold (mirrored in descending mode).
  function automatic logic sinks(temp_t t, temp_t thr);
    return mirror_descending ? (t > thr) : (t < thr);
  endfunction

  // Work out the level that a sample leads to from the tracked level.
  // A zero level count acts as one; a level above the count is first
  // pulled down to the count. Climb and drop are exclusive per sample.
  function automatic level_t advance_level(temp_t t);
    int n;
    int lev;
    n = (mirror_levels == 2'd0) ? 1 : int'(mirror_levels);
    if (n > int'(MAX_LEVELS)) n = int'(MAX_LEVELS);
    lev = (int'(tracked_level) > n) ? n : int'(tracked_level);
    if (lev < n && climbs(t, mirror_rise[lev])) begin
      while (lev < n && climbs(t, mirror_rise[lev])) lev++;
    end else if (lev > 0 && sinks(t, mirror_clear[lev-1])) begin
      while (lev > 0 && sinks(t, mirror_clear[lev-1])) lev--;
    end
    return level_t'(lev);
  endfunction

  function automatic temp_t clamp_temp(int v);
    if (v > 262143) v = 262143;
    else if (v < -262144) v = -262144;
    return temp_t'(v);
  endfunction

  function automatic temp_t extreme_temp();
    case ($urandom_range(0, 3))
      0:       return TEMP_MIN;
      1:       return TEMP_MAX;
      2:       return temp_t'(0);
      default: return temp_t'(-1);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) $display("[%0t] %s", $time, what);
    mismatch_count++;
  endtask

  // ------------------------------------------------------------------------
  // Register writes: only issued while nothing is in flight, so the shadow
  // copy can be updated right at the accepting edge.
  // ------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_t idx, input logic [TEMP_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // scramble the idle bus so a core that ignores cfg_valid gets caught
    cfg_index <= cfg_idx_t'($urandom);
    cfg_data  <= temp_t'($urandom);
    case (idx)
      REG_DESCENDING: mirror_descending = data[0];
      REG_LEVELS:     mirror_levels = data[LEVEL_W-1:0];
      REG_RISE_ONE:   mirror_rise[0] = temp_t'(data);
      REG_RISE_TWO:   mirror_rise[1] = temp_t'(data);
      REG_RISE_THREE: mirror_rise[2] = temp_t'(data);
      REG_CLR_ONE:    mirror_clear[0] = temp_t'(data);
      REG_CLR_TWO:    mirror_clear[1] = temp_t'(data);
      default:        mirror_clear[2] = temp_t'(data);
    endcase
  endtask

  // Hold until the driver has nothing left and every level word is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (temp_backlog.size() != 0 || in_valid || level_due.size() != 0);
  endtask

  // ------------------------------------------------------------------------
  // Driver: present samples in bursts with random gaps; hold the word while
  // stalled; predict the level at the edge where a word is taken.
  // ------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_temperature <= '0;
      tracked_level  = '0;
      level_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        tracked_level = advance_level(in_temperature);
        level_due.push_back(tracked_level);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid       <= 1'b0;
          in_temperature <= temp_t'($urandom);
        end else if (temp_backlog.size() != 0) begin
          in_valid       <= 1'b1;
          in_temperature <= temp_backlog.pop_front();
          if (burst_left <= 1) begin
            // close the burst: some bursts run long with no gap after them
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid       <= 1'b0;
          in_temperature <= temp_t'($urandom);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: check each delivered level word against the oldest prediction,
  // and stall on a pattern that switches between none, sparse and runs.
  // ------------------------------------------------------------------------
  stall_mode_e stall_mode = STALL_NONE;
  int          stretch_left = 0;
  int          run_left = 0;
  logic        run_high = 1'b0;
  level_t      want_level;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        level_words_seen++;
        if (level_due.size() == 0) begin
          report_mismatch($sformatf("level word %0d arrived with nothing predicted",
                                    out_thermal_level));
        end else begin
          want_level = level_due.pop_front();
          if (out_thermal_level !== want_level)
            report_mismatch($sformatf("level word %0d: got %0d, predicted %0d",
                                      level_words_seen, out_thermal_level, want_level));
        end
      end
      if (stretch_left == 0) begin
        stall_mode   = stall_mode_e'($urandom_range(0, 2));
        stretch_left = $urandom_range(20, 150);
      end
      stretch_left--;
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          if (run_left == 0) begin
            run_left = $urandom_range(1, 10);
            run_high = ~run_high;
          end
          run_left--;
          out_stall <= run_high;
        end
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  initial begin
    setup_style_e      style;
    int                base;
    int                step;
    int                hyst;
    int                dir;
    int                off;
    int                lv;
    temp_t             rise_pick [NUM_ENTRY];
    temp_t             clear_pick [NUM_ENTRY];
    temp_t             t;
    logic [TEMP_W-1:0] reg_word;
    logic              desc_pick;

    mirror_descending = 1'b0;
    mirror_levels     = RST_LEVELS;
    mirror_rise       = '{RST_RISE_ONE, RST_RISE_TWO, RST_RISE_THREE};
    mirror_clear      = '{RST_CLR_ONE, RST_CLR_TWO, RST_CLR_THREE};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset thresholds, ascending, three levels: hold at zero, single climb,
    // multi-step climb, partial drop, full drop from the floor sample, full
    // climb from the ceiling sample, equality on a clear threshold (holds),
    // multi-step drop, and both edges of the first rise and clear.
    temp_backlog = '{temp_t'(0), temp_t'(60000), temp_t'(80000), temp_t'(74999),
                     TEMP_MIN, TEMP_MAX, temp_t'(75000), temp_t'(54999),
                     temp_t'(59999), temp_t'(60000), temp_t'(55000), temp_t'(54999)};
    wait_drained();

    // Climb to the top, then shrink the table to one level: the level is
    // pulled down to one before the sample is judged.
    temp_backlog.push_back(temp_t'(131071));
    wait_drained();
    write_reg(REG_LEVELS, 19'd1);
    @(negedge clk);
    temp_backlog = '{temp_t'(57000), temp_t'(0)};
    wait_drained();

    // Descending mode, a zero level count (acts as one), junk in the upper
    // data bits, and thresholds at the ends of the range.
    write_reg(REG_DESCENDING, 19'h7FFFF);
    write_reg(REG_LEVELS, 19'h7FFFC);
    write_reg(REG_RISE_ONE, TEMP_MAX);
    write_reg(REG_CLR_ONE, TEMP_MIN);
    @(negedge clk);
    temp_backlog = '{TEMP_MIN, TEMP_MIN, temp_t'(0), TEMP_MAX};
    wait_drained();

    // Mirrored comparisons around ordinary thresholds.
    write_reg(REG_RISE_ONE, -19'sd1000);
    write_reg(REG_CLR_ONE, 19'sd0);
    @(negedge clk);
    temp_backlog = '{temp_t'(1), temp_t'(-999), temp_t'(-1000), temp_t'(0), temp_t'(1)};

    // Random phases: fresh setup each phase, samples mostly near thresholds.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      style     = (phase < 3) ? setup_style_e'(phase) : setup_style_e'($urandom_range(0, 2));
      desc_pick = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      lv        = (phase == 0) ? 1 : (phase == 1) ? 3 : (phase == 2) ? 0
                : (phase == 3) ? 2 : $urandom_range(0, 3);

      // ordered tables have hysteresis in the direction the mode implies
      base = $urandom_range(0, 240000);
      base -= 120000;
      step = $urandom_range(1, 6000);
      hyst = $urandom_range(0, 3000);
      dir  = desc_pick ? -1 : 1;
      for (int k = 0; k < NUM_ENTRY; k++) begin
        case (style)
          SETUP_ORDERED: begin
            rise_pick[k]  = clamp_temp(base + dir * k * step);
            clear_pick[k] = clamp_temp(base + dir * k * step - dir * hyst);
          end
          SETUP_SCATTERED: begin
            rise_pick[k]  = temp_t'($urandom);
            clear_pick[k] = temp_t'($urandom);
          end
          default: begin
            rise_pick[k]  = extreme_temp();
            clear_pick[k] = extreme_temp();
          end
        endcase
      end

      reg_word = temp_t'($urandom);
      reg_word[0] = desc_pick;
      write_reg(REG_DESCENDING, reg_word);
      reg_word = temp_t'($urandom);
      if ($urandom_range(0, 1)) reg_word = '0;
      reg_word[LEVEL_W-1:0] = lv[LEVEL_W-1:0];
      write_reg(REG_LEVELS, reg_word);
      write_reg(REG_RISE_ONE, rise_pick[0]);
      write_reg(REG_RISE_TWO, rise_pick[1]);
      write_reg(REG_RISE_THREE, rise_pick[2]);
      write_reg(REG_CLR_ONE, clear_pick[0]);
      write_reg(REG_CLR_TWO, clear_pick[1]);
      write_reg(REG_CLR_THREE, clear_pick[2]);
      @(negedge clk);

      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // hold the sender mid-phase until every level word is back
        if (i == WORDS_PER_PHASE / 2) wait_drained();
        off = $urandom_range(0, 99);
        if (off < 60) begin
          lv  = $urandom_range(0, 2 * NUM_ENTRY - 1);
          t   = (lv < NUM_ENTRY) ? mirror_rise[lv] : mirror_clear[lv - NUM_ENTRY];
          off = $urandom_range(0, 40);
          t   = clamp_temp(int'(t) + off - 20);
        end else if (off < 88) begin
          t = temp_t'($urandom);
        end else begin
          t = extreme_temp();
        end
        temp_backlog.push_back(t);
      end
    end

    wait_drained();
    // let any stray level word surface before the verdict
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ thermal_level_hysteresis_core.f @@
design/tlh_pkg.sv
design/tlh_level_calc.sv
design/thermal_level_hysteresis_core.sv
design/tlh_checker.sv
test/thermal_level_hysteresis_core_test.sv
